/* hdl/brs_pkg.sv */
package brs_pkg;

    localparam int WORDS           = 1024;
    localparam int UNITS_PER_BLOCK = 4;
    localparam int UNIT_BITS       = 64;
    localparam int BLOCKS          = WORDS / UNITS_PER_BLOCK;
    localparam int WIDX_W          = $clog2(WORDS);
    localparam int UNIT_W          = $clog2(UNITS_PER_BLOCK);
    localparam int BLK_W           = WIDX_W - UNIT_W;
    localparam int BIT_W           = $clog2(UNIT_BITS);
    localparam int CNT_W           = 17;
    localparam int POS_W           = 16;
    localparam int PC_W            = BIT_W + 1;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RANK    = 2'd1,
        OP_SELECT1 = 2'd2,
        OP_SELECT0 = 2'd3
    } op_t;

    typedef struct packed {
        logic load_start;
        logic load_write;
        logic rank_start;
        logic rank_finish;
        logic sel_start;
        logic sel_step;
        logic byte_step;
    } brs_cmd_t;

    typedef struct packed {
        logic sel_miss;
        logic word_hit;
        logic byte_hit;
    } brs_stat_t;

    // adder tree
    function automatic logic [PC_W-1:0] popcount64(input logic [UNIT_BITS-1:0] x);
        logic [1:0] p2  [32];
        logic [2:0] p4  [16];
        logic [3:0] p8  [8];
        logic [4:0] p16 [4];
        logic [5:0] p32 [2];
        for (int i = 0; i < 32; i++)
        begin
            p2[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            p4[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            p8[i] = {1'b0, p4[2*i]} + {1'b0, p4[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            p16[i] = {1'b0, p8[2*i]} + {1'b0, p8[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            p32[i] = {1'b0, p16[2*i]} + {1'b0, p16[2*i+1]};
        end
        return {1'b0, p32[0]} + {1'b0, p32[1]};
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] x);
        logic [1:0] q2 [4];
        logic [2:0] q4 [2];
        for (int i = 0; i < 4; i++)
        begin
            q2[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            q4[i] = {1'b0, q2[2*i]} + {1'b0, q2[2*i+1]};
        end
        return {1'b0, q4[0]} + {1'b0, q4[1]};
    endfunction

endpackage

/* hdl/brs_ctrl.sv */
module brs_ctrl
    import brs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic [1:0] operation,
    output logic      out_valid,
    input  logic      out_stall,
    output brs_cmd_t  cmd,
    input  brs_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RANK_RD,
        S_RANK_SUM,
        S_SEL,
        S_SEL_BYTE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   acc;

    assign in_stall  = (state_reg != S_IDLE) && !(state_reg == S_OUT && !out_stall);
    assign acc       = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd = '0;
        cmd.load_start  = acc && (op_t'(operation) == OP_LOAD);
        cmd.load_write  = (state_reg == S_LOAD);
        cmd.rank_start  = acc && (op_t'(operation) == OP_RANK);
        cmd.sel_start   = acc && (operation[1]);
        cmd.rank_finish = (state_reg == S_RANK_SUM);
        cmd.sel_step    = (state_reg == S_SEL);
        cmd.byte_step   = (state_reg == S_SEL_BYTE);
        state_next = state_reg;
        case (state_reg)
            S_IDLE, S_OUT:
            begin
                if (state_reg == S_OUT && !out_stall)
                    state_next = S_IDLE;
                if (acc)
                begin
                    case (op_t'(operation))
                        OP_LOAD: state_next = S_LOAD;
                        OP_RANK: state_next = S_RANK_RD;
                        default: state_next = S_SEL;
                    endcase
                end
            end
            S_LOAD:     state_next = S_OUT;
            S_RANK_RD:  state_next = S_RANK_SUM;
            S_RANK_SUM: state_next = S_OUT;
            S_SEL:
            begin
                if (stat.sel_miss)
                    state_next = S_OUT;
                else if (stat.word_hit)
                    state_next = S_SEL_BYTE;
            end
            S_SEL_BYTE: if (stat.byte_hit) state_next = S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) != S_IDLE))
        else $error("result without work");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_start, cmd.rank_start, cmd.sel_start}))
        else $error("multiple starts");
    a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEL) |-> !acc)
        else $error("accepted while selecting");

endmodule

/* hdl/brs_datapath.sv */
module brs_datapath
    import brs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  brs_cmd_t          cmd,
    output brs_stat_t         stat,
    input  logic [CNT_W-1:0]  bit_length,
    input  logic [1:0]        operation,
    input  logic [WIDX_W-1:0] word_index,
    input  logic [63:0]       word_data,
    input  logic [POS_W-1:0]  position,
    input  logic [CNT_W-1:0]  target_count,
    output logic [CNT_W-1:0]  answer,
    output logic              error
);

    logic [63:0]      words_mem [WORDS];
    logic [CNT_W-1:0] blk_mem   [BLOCKS];
    logic [CNT_W-1:0] unit_mem  [WORDS];

    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  answer_reg, answer_next;
    logic              error_reg, error_next;
    logic [63:0]       wrd_reg;
    logic [CNT_W-1:0]  brk_reg, urk_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic              rank_bad_reg;
    logic [WIDX_W-1:0] ld_idx_reg;
    logic [CNT_W-1:0]  ld_tot_reg;
    logic              ones_reg;
    logic [CNT_W-1:0]  left_reg, limit_reg;
    logic [WIDX_W:0]   w_reg;
    logic [63:0]       sv_reg;
    logic [2:0]        byte_reg;
    logic [WIDX_W-1:0] rd_addr;
    logic [BLK_W-1:0]  blk_addr;
    logic [PC_W-1:0]   ld_pc;
    logic [CNT_W-1:0]  lim;
    logic [63:0]       sv;
    logic [CNT_W-1:0]  base, vld;
    logic [PC_W-1:0]   sc;
    logic              sel_miss;
    logic              word_hit;
    logic [7:0]        byte_v;
    logic [3:0]        bc;
    logic [3:0]        acc_b;
    logic [2:0]        bpos;
    logic              byte_hit;
    logic [CNT_W-1:0]  sel_ans;
    logic [63:0]       rmask;

    // word store read port shared between rank and select
    assign rd_addr = cmd.rank_start ? position[POS_W-1:BIT_W] :
                     cmd.sel_start  ? '0 : (w_reg[WIDX_W-1:0] + WIDX_W'(1));
    // block rank read port shared between rank and load
    assign blk_addr = cmd.rank_start ? position[POS_W-1:BIT_W+UNIT_W] :
                      word_index[WIDX_W-1:UNIT_W];
    assign ld_pc = popcount64(word_data);
    assign lim = (bit_length > CNT_W'(WORDS * UNIT_BITS)) ?
                 CNT_W'(WORDS * UNIT_BITS) : bit_length;

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            words_mem[word_index] <= word_data;
            if (word_index[UNIT_W-1:0] == '0)
                blk_mem[word_index[WIDX_W-1:UNIT_W]] <=
                    (word_index == '0) ? '0 : total_reg;
            ld_idx_reg <= word_index;
            ld_tot_reg <= (word_index == '0) ? '0 : total_reg;
        end
        // unit rank is relative to the rank of the word's own block
        if (cmd.load_write && ld_idx_reg[UNIT_W-1:0] != '0)
            unit_mem[ld_idx_reg] <= ld_tot_reg - brk_reg;
        if (cmd.rank_start || cmd.sel_start || cmd.sel_step)
            wrd_reg <= words_mem[rd_addr];
        if (cmd.rank_start || cmd.load_start)
            brk_reg <= blk_mem[blk_addr];
        if (cmd.rank_start)
        begin
            urk_reg <= (position[BIT_W+UNIT_W-1:BIT_W] == '0) ? '0 :
                       unit_mem[position[POS_W-1:BIT_W]];
            bit_reg <= position[BIT_W-1:0];
            rank_bad_reg <= ({1'b0, position} >= bit_length);
        end
    end

    // select word scan
    always_comb
    begin
        base = CNT_W'({w_reg, {BIT_W{1'b0}}});
        vld  = limit_reg - base;
        sv   = ones_reg ? wrd_reg : ~wrd_reg;
        if (vld < CNT_W'(UNIT_BITS))
            sv = sv & ~(~64'd0 << vld[BIT_W-1:0]);
        sc = popcount64(sv);
        sel_miss = (base >= limit_reg) || (w_reg == (WIDX_W+1)'(WORDS));
        word_hit = !sel_miss && (left_reg <= CNT_W'(sc));
    end

    // select byte scan inside the matching word
    always_comb
    begin
        byte_v   = sv_reg[7:0];
        bc       = popcount8(byte_v);
        byte_hit = (left_reg <= CNT_W'(bc));
        acc_b    = '0;
        bpos     = '0;
        for (int b = 0; b < 8; b++)
        begin
            acc_b = acc_b + 4'(byte_v[b]);
            if (byte_v[b] && CNT_W'(acc_b) == left_reg)
                bpos = 3'(b);
        end
        sel_ans = base | CNT_W'({byte_reg, bpos});
    end

    assign stat.sel_miss = sel_miss;
    assign stat.word_hit = word_hit;
    assign stat.byte_hit = byte_hit;

    assign rmask = ~64'd0 >> (BIT_W'(UNIT_BITS - 1) - bit_reg);

    always_comb
    begin
        total_next  = total_reg;
        answer_next = answer_reg;
        error_next  = error_reg;
        if (cmd.load_start)
        begin
            total_next  = ((word_index == '0) ? '0 : total_reg) + CNT_W'(ld_pc);
            answer_next = '0;
            error_next  = 1'b0;
        end
        if (cmd.rank_finish)
        begin
            answer_next = rank_bad_reg ? '0 :
                          brk_reg + urk_reg + CNT_W'(popcount64(wrd_reg & rmask));
            error_next  = rank_bad_reg;
        end
        if (cmd.sel_step && sel_miss)
        begin
            answer_next = '0;
            error_next  = 1'b1;
        end
        if (cmd.byte_step && byte_hit)
        begin
            answer_next = sel_ans;
            error_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else
            total_reg <= total_next;
    end

    always_ff @(posedge clk)
    begin
        answer_reg <= answer_next;
        error_reg  <= error_next;
        if (cmd.sel_start)
        begin
            ones_reg  <= (op_t'(operation) == OP_SELECT1);
            left_reg  <= target_count;
            limit_reg <= (target_count == '0) ? '0 : lim;
            w_reg     <= '0;
        end
        else if (cmd.sel_step && !sel_miss)
        begin
            if (word_hit)
            begin
                sv_reg   <= sv;
                byte_reg <= '0;
            end
            else
            begin
                left_reg <= left_reg - CNT_W'(sc);
                w_reg    <= w_reg + (WIDX_W+1)'(1);
            end
        end
        else if (cmd.byte_step && !byte_hit)
        begin
            left_reg <= left_reg - CNT_W'(bc);
            sv_reg   <= sv_reg >> 8;
            byte_reg <= byte_reg + 3'd1;
        end
    end

    assign answer = answer_reg;
    assign error  = error_reg;

endmodule

/* hdl/bitvector_rank_select.sv */
// Rank/select engine over a 65536-bit vector.
// Requests come on the in_ channel (valid/stall), results leave on the
// out_ channel (valid/stall); one result per request.
// The user writes bit_length over cfg_valid/cfg_ready only while the
// block is idle, and the block itself does not enforce it.
// Load (operation 0) stores one 64-bit word and extends the rank
// directory; words go in ascending order, index 0 restarts it.
// Load stores the word and reads the block rank, then writes the unit
// rank; rank reads the directory and word, then sums; select makes word
// steps through a single popcount unit (the last may only detect the end
// of the vector), then byte steps in the matching word, none on a miss.
// One request is in flight at a time; the next is taken in the cycle its
// predecessor's result is taken.
// A stalled result holds on the outputs and blocks new requests.
// Reset clears bit_length and the running count; stored words and the
// directory are unknown until loaded.
module bitvector_rank_select
    import brs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] bit_length,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [9:0]  word_index,
    input  logic [63:0] word_data,
    input  logic [15:0] position,
    input  logic [16:0] target_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] answer,
    output logic        error
);

    brs_cmd_t         cmd;
    brs_stat_t        stat;
    logic [CNT_W-1:0] bitlen_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bitlen_reg <= '0;
        else if (cfg_valid)
            bitlen_reg <= bit_length;
    end

    brs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    brs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .bit_length   (bitlen_reg),
        .operation    (operation),
        .word_index   (word_index),
        .word_data    (word_data),
        .position     (position),
        .target_count (target_count),
        .answer       (answer),
        .error        (error)
    );

endmodule
